// ===== sv/grr_pkg.sv =====
// ----------------------------------------------------------------------------
// grr_pkg: shared types and constants of the glyph row rasterizer
// Register indexes, address unit operations, config and control structs.
// ----------------------------------------------------------------------------
package grr_pkg;

  localparam int DEF_MAX_GLYPH_WIDTH  = 48;
  localparam int DEF_MAX_GLYPH_HEIGHT = 62;
  localparam int DEF_ATLAS_BYTES      = 16384;

  localparam int CFG_IDX_W  = 3;
  localparam int LINE_W     = 11;
  localparam int PIX_ADDR_W = 25;

  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_LO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_MID_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_MID_HI = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_HI     = 3'd6;

  localparam logic [12:0] RST_ATLAS_WIDTH = 13'd256;
  localparam logic [5:0]  RST_FONT_HEIGHT = 6'd62;
  localparam logic [8:0]  RST_CLIP_HEIGHT = 9'd320;

  localparam logic [1:0] AU_HOLD = 2'd0;
  localparam logic [1:0] AU_MUL  = 2'd1;
  localparam logic [1:0] AU_ADD  = 2'd2;

  typedef struct packed {
    logic [12:0]      atlas_width;
    logic [5:0]       font_height;
    logic [8:0]       clip_height;
    logic [3:0][63:0] palette;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [LINE_W-1:0] line;
    logic [11:0]       addend;
  } au_ctrl_t;

endpackage

// ===== sv/glyph_row_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// glyph_row_rasterizer_top: 4bpp font atlas glyph row renderer
// Config registers, atlas memory, address unit and row sequencer.
// ----------------------------------------------------------------------------
// Input channel (in_*): action 0 stores atlas_byte at atlas_addr. Action 1
// renders one cell row; the block then drops in_ready until the row's last
// pixel is loaded into the output register. Setup runs a limit check, line
// times stride, a column base add and the first read, then one pixel per
// cycle from the single atlas read port while the output is not stalled. A
// rejected row returns to idle after its limit check.
// Output channel (out_*): one transfer per pixel, left to right, with
// out_last_pixel on the final one. A stall on out_ready holds the output
// register and pauses pixel stepping; the next input transfer can be taken
// while the last pixel of a row still waits.
// Config port (cfg_*): always ready; the user must see that it is written
// only while idle, which the block does not enforce. Unknown indexes are
// ignored. Reset restores register defaults (stride 256, font height 62,
// clip height 320, palette zero); atlas contents stay undefined.
// ATLAS_BYTES must be a power of two; addresses wrap modulo its size.
// ----------------------------------------------------------------------------
module glyph_row_rasterizer_top #(
  parameter int MAX_GLYPH_WIDTH  = grr_pkg::DEF_MAX_GLYPH_WIDTH,
  parameter int MAX_GLYPH_HEIGHT = grr_pkg::DEF_MAX_GLYPH_HEIGHT,
  parameter int ATLAS_BYTES      = grr_pkg::DEF_ATLAS_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [grr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [13:0]                   in_atlas_addr,
  input  logic [7:0]                    in_atlas_byte,
  input  logic [11:0]                   in_glyph_x,
  input  logic [9:0]                    in_glyph_y,
  input  logic [5:0]                    in_glyph_width,
  input  logic [5:0]                    in_glyph_height,
  input  logic [5:0]                    in_offset_x,
  input  logic [5:0]                    in_offset_y,
  input  logic [5:0]                    in_advance_width,
  input  logic [8:0]                    in_avail_width,
  input  logic [5:0]                    in_row_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   out_pixel_color,
  output logic                          out_last_pixel,
  output logic [5:0]                    out_run_width
);

  localparam int AW = $clog2(ATLAS_BYTES);

  grr_pkg::cfg_t cfg_r;
  grr_pkg::au_ctrl_t au_ctrl;
  logic [grr_pkg::PIX_ADDR_W-1:0] pix_addr;
  logic [grr_pkg::PIX_ADDR_W-2:0] byte_addr;
  logic [23:0] waddr_wide;
  logic [AW-1:0] waddr, raddr;
  logic we, rd_en;
  logic [7:0] rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.atlas_width <= grr_pkg::RST_ATLAS_WIDTH;
      cfg_r.font_height <= grr_pkg::RST_FONT_HEIGHT;
      cfg_r.clip_height <= grr_pkg::RST_CLIP_HEIGHT;
      cfg_r.palette     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        grr_pkg::CFG_ATLAS_WIDTH:    cfg_r.atlas_width <= cfg_data[12:0];
        grr_pkg::CFG_FONT_HEIGHT:    cfg_r.font_height <= cfg_data[5:0];
        grr_pkg::CFG_CLIP_HEIGHT:    cfg_r.clip_height <= cfg_data[8:0];
        grr_pkg::CFG_PALETTE_LO:     cfg_r.palette[0]  <= cfg_data;
        grr_pkg::CFG_PALETTE_MID_LO: cfg_r.palette[1]  <= cfg_data;
        grr_pkg::CFG_PALETTE_MID_HI: cfg_r.palette[2]  <= cfg_data;
        grr_pkg::CFG_PALETTE_HI:     cfg_r.palette[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign we         = in_valid && in_ready && !in_action;
  assign waddr_wide = 24'(in_atlas_addr);
  assign waddr      = waddr_wide[AW-1:0];
  assign byte_addr  = pix_addr[grr_pkg::PIX_ADDR_W-1:1];
  assign raddr      = byte_addr[AW-1:0];

  grr_atlas_mem #(
    .ATLAS_BYTES(ATLAS_BYTES)
  ) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(in_atlas_byte),
    .re   (rd_en),
    .raddr(raddr),
    .rdata(rd_data)
  );

  grr_addr_unit u_au (
    .clk     (clk),
    .ctrl    (au_ctrl),
    .stride  (cfg_r.atlas_width),
    .pix_addr(pix_addr)
  );

  grr_seq #(
    .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH),
    .MAX_GLYPH_HEIGHT(MAX_GLYPH_HEIGHT)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_glyph_x      (in_glyph_x),
    .in_glyph_y      (in_glyph_y),
    .in_glyph_width  (in_glyph_width),
    .in_glyph_height (in_glyph_height),
    .in_offset_x     (in_offset_x),
    .in_offset_y     (in_offset_y),
    .in_advance_width(in_advance_width),
    .in_avail_width  (in_avail_width),
    .in_row_number   (in_row_number),
    .pix_addr        (pix_addr),
    .au_ctrl         (au_ctrl),
    .rd_en           (rd_en),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel),
    .out_run_width   (out_run_width)
  );

endmodule

// ===== sv/grr_atlas_mem.sv =====
// ----------------------------------------------------------------------------
// grr_atlas_mem: font atlas byte memory
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module grr_atlas_mem #(
  parameter int ATLAS_BYTES = grr_pkg::DEF_ATLAS_BYTES,
  localparam int AW = $clog2(ATLAS_BYTES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [ATLAS_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/grr_addr_unit.sv =====
// ----------------------------------------------------------------------------
// grr_addr_unit: shared atlas pixel address unit
// Multiplies line by stride, then adds column base and per-pixel steps.
// ----------------------------------------------------------------------------
module grr_addr_unit (
  input  logic                            clk,
  input  grr_pkg::au_ctrl_t               ctrl,
  input  logic [12:0]                     stride,
  output logic [grr_pkg::PIX_ADDR_W-1:0]  pix_addr
);

  logic [grr_pkg::PIX_ADDR_W-1:0] acc_r;
  logic [grr_pkg::PIX_ADDR_W-1:0] acc_nxt;

  always_comb begin
    case (ctrl.op)
      grr_pkg::AU_MUL: acc_nxt = grr_pkg::PIX_ADDR_W'(ctrl.line) *
                                 grr_pkg::PIX_ADDR_W'(stride);
      grr_pkg::AU_ADD: acc_nxt = acc_r + grr_pkg::PIX_ADDR_W'(ctrl.addend);
      default:         acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign pix_addr = acc_r;

endmodule

// ===== sv/grr_seq.sv =====
// ----------------------------------------------------------------------------
// grr_seq: row sequencer of the glyph row rasterizer
// Row setup, pixel stepping, palette lookup and the output register.
// ----------------------------------------------------------------------------
module grr_seq #(
  parameter int MAX_GLYPH_WIDTH  = grr_pkg::DEF_MAX_GLYPH_WIDTH,
  parameter int MAX_GLYPH_HEIGHT = grr_pkg::DEF_MAX_GLYPH_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  grr_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [11:0]                    in_glyph_x,
  input  logic [9:0]                     in_glyph_y,
  input  logic [5:0]                     in_glyph_width,
  input  logic [5:0]                     in_glyph_height,
  input  logic [5:0]                     in_offset_x,
  input  logic [5:0]                     in_offset_y,
  input  logic [5:0]                     in_advance_width,
  input  logic [8:0]                     in_avail_width,
  input  logic [5:0]                     in_row_number,
  input  logic [grr_pkg::PIX_ADDR_W-1:0] pix_addr,
  output grr_pkg::au_ctrl_t              au_ctrl,
  output logic                           rd_en,
  input  logic [7:0]                     rd_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [15:0]                    out_pixel_color,
  output logic                           out_last_pixel,
  output logic [5:0]                     out_run_width
);

  localparam int RW = $clog2(MAX_GLYPH_WIDTH + 1);
  localparam logic [8:0] MAXW9 = 9'(MAX_GLYPH_WIDTH);
  localparam logic [8:0] MAXH9 = 9'(MAX_GLYPH_HEIGHT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_BASE = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_PX   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [RW-1:0] pos_r, pos_nxt;
  logic px_data_r, px_data_nxt;
  logic px_last_r, px_last_nxt;
  logic px_nib_r, px_nib_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [11:0] gx_r;
  logic [9:0]  gy_r;
  logic [5:0]  gw_r, gh_r, sx_r, sy_r, adv_r, row_r;
  logic [8:0]  avail_r;
  logic [RW-1:0] run_r, de_r;
  logic gl_r;
  logic [grr_pkg::LINE_W-1:0] line_r;
  logic [15:0] color_r;
  logic last_r;
  logic [5:0] runw_r;

  logic accept;
  logic [8:0] lower, de9, run9, font9, clip9;
  logic [6:0] sy_end;
  logic gl;
  logic [grr_pkg::LINE_W-1:0] line_v;
  logic reject;
  logic [8:0] pos9;
  logic [RW:0] pos_inc;
  logic data_px, last_px;
  logic slot_free, issue, load;
  logic [3:0] nib, idx;
  logic [8:0] run_ext;

  assign accept = in_valid && in_ready && in_action;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    font9 = 9'(cfg.font_height);
    clip9 = cfg.clip_height;
    lower = (clip9 < font9) ? clip9 : font9;
    if (lower > MAXH9) lower = MAXH9;
    de9  = 9'(sx_r) + 9'(gw_r);
    run9 = (de9 > 9'(adv_r)) ? de9 : 9'(adv_r);
    if (de9 > avail_r) begin
      de9  = avail_r;
      run9 = avail_r;
    end else if (run9 > avail_r) begin
      run9 = avail_r;
    end
    if (run9 > MAXW9) run9 = MAXW9;
    if (de9 > run9) de9 = run9;
    sy_end = 7'(sy_r) + 7'(gh_r);
    gl = (row_r >= sy_r) && (7'(row_r) < sy_end);
    line_v = grr_pkg::LINE_W'(gy_r) + (gl ? grr_pkg::LINE_W'(row_r - sy_r) : '0);
    reject = (9'(row_r) >= lower) || (9'(sx_r) >= avail_r) || (run9 == 9'd0);
  end

  always_comb begin
    pos9    = 9'(pos_r);
    pos_inc = {1'b0, pos_r} + 1'b1;
    data_px = gl_r && (pos9 >= 9'(sx_r)) && (pos9 < 9'(de_r));
    last_px = (pos_inc == {1'b0, run_r});
  end

  assign slot_free = !out_valid_r || out_ready;
  assign issue = (state_r == S_RD) || ((state_r == S_PX) && slot_free && !px_last_r);
  assign load  = (state_r == S_PX) && slot_free;
  assign rd_en = issue && data_px;

  assign nib = px_nib_r ? rd_data[3:0] : rd_data[7:4];
  assign idx = px_data_r ? nib : 4'd0;
  assign run_ext = 9'(run_r);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    px_data_nxt   = px_data_r;
    px_last_nxt   = px_last_r;
    px_nib_nxt    = px_nib_r;
    out_valid_nxt = out_valid_r;
    au_ctrl.op     = grr_pkg::AU_HOLD;
    au_ctrl.line   = line_r;
    au_ctrl.addend = gx_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_CALC;
      S_CALC: state_nxt = reject ? S_IDLE : S_MUL;
      S_MUL: begin
        au_ctrl.op = grr_pkg::AU_MUL;
        state_nxt  = S_BASE;
      end
      S_BASE: begin
        au_ctrl.op = grr_pkg::AU_ADD;
        pos_nxt    = '0;
        state_nxt  = S_RD;
      end
      S_RD: state_nxt = S_PX;
      S_PX: if (load && px_last_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (issue) begin
      pos_nxt     = pos_inc[RW-1:0];
      px_data_nxt = data_px;
      px_last_nxt = last_px;
      px_nib_nxt  = pix_addr[0];
      if (data_px) begin
        au_ctrl.op     = grr_pkg::AU_ADD;
        au_ctrl.addend = 12'd1;
      end
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      px_data_r   <= 1'b0;
      px_last_r   <= 1'b0;
      px_nib_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      px_data_r   <= px_data_nxt;
      px_last_r   <= px_last_nxt;
      px_nib_r    <= px_nib_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gx_r    <= in_glyph_x;
      gy_r    <= in_glyph_y;
      gw_r    <= in_glyph_width;
      gh_r    <= in_glyph_height;
      sx_r    <= in_offset_x;
      sy_r    <= in_offset_y;
      adv_r   <= in_advance_width;
      avail_r <= in_avail_width;
      row_r   <= in_row_number;
    end
    if (state_r == S_CALC) begin
      run_r  <= run9[RW-1:0];
      de_r   <= de9[RW-1:0];
      gl_r   <= gl;
      line_r <= line_v;
    end
    if (load) begin
      color_r <= cfg.palette[idx[3:2]][{idx[1:0], 4'b0000} +: 16];
      last_r  <= px_last_r;
      runw_r  <= run_ext[5:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = color_r;
  assign out_last_pixel  = last_r;
  assign out_run_width   = runw_r;

`ifndef SYNTH
  a_rd_in_px: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (state_r == S_RD || state_r == S_PX))
    else $error("atlas read outside pixel stepping");

  a_out_from_px: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_PX)
    else $error("output transfer raised outside pixel stepping");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PX) |-> (pos_r <= run_r))
    else $error("pixel position beyond run");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PX && px_last_r && slot_free) |=> (state_r == S_IDLE && out_last_pixel))
    else $error("row did not finish after last pixel");
`endif

endmodule

// ===== dv/tb_glyph_row_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// tb_glyph_row_rasterizer_top: self-checking bench for the glyph row renderer
// Drives atlas writes and row requests over valid/ready with random gaps and
// output stalls. A cycle-free predictor tracks the atlas and registers and
// queues the expected pixels of every accepted row; each transfer is checked
// in order. Reset values, directed cases, register extremes, random traffic.
// ----------------------------------------------------------------------------
module tb_glyph_row_rasterizer_top;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_RENDER = 1'b1;
  localparam int RANDOM_ITEMS = 60;
  localparam int RANDOM_PHASES = 6;
  localparam int SETTLE_LIMIT = 100000;
  localparam int QUIET_CYCLES = 12;

  typedef struct {
    logic        action;
    logic [13:0] addr;
    logic [7:0]  data;
    logic [11:0] gx;
    logic [9:0]  gy;
    logic [5:0]  gw;
    logic [5:0]  gh;
    logic [5:0]  sx;
    logic [5:0]  sy;
    logic [5:0]  adv;
    logic [8:0]  avail;
    logic [5:0]  row;
  } glyph_req_t;

  typedef struct packed {
    logic [15:0] color;
    logic        last;
    logic [5:0]  width;
  } pixel_t;

  typedef struct {
    int     run;
    int     first;
    int     stop;
    bit     glyph;
    longint base;
  } row_plan_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [grr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [13:0] in_atlas_addr;
  logic [7:0]  in_atlas_byte;
  logic [11:0] in_glyph_x;
  logic [9:0]  in_glyph_y;
  logic [5:0]  in_glyph_width;
  logic [5:0]  in_glyph_height;
  logic [5:0]  in_offset_x;
  logic [5:0]  in_offset_y;
  logic [5:0]  in_advance_width;
  logic [8:0]  in_avail_width;
  logic [5:0]  in_row_number;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_pixel_color;
  logic        out_last_pixel;
  logic [5:0]  out_run_width;

  // predictor state
  logic [7:0]  atlas_copy [grr_pkg::DEF_ATLAS_BYTES];
  bit          written_map [grr_pkg::DEF_ATLAS_BYTES];
  logic [12:0] stride_q = grr_pkg::RST_ATLAS_WIDTH;
  logic [5:0]  font_h   = grr_pkg::RST_FONT_HEIGHT;
  logic [8:0]  clip_h   = grr_pkg::RST_CLIP_HEIGHT;
  logic [63:0] palette_q [4] = '{default: 64'd0};
  pixel_t      pending_pixels [$];

  int  mismatches = 0;
  int  pixels_checked = 0;
  int  items_sent = 0;
  int  rows_sent = 0;
  int  writes_sent = 0;
  int  cfg_writes = 0;
  bit  gaps_on = 1'b1;
  int  pool_x [4];
  int  pool_y [4];

  glyph_row_rasterizer_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_atlas_addr(in_atlas_addr),
    .in_atlas_byte(in_atlas_byte), .in_glyph_x(in_glyph_x),
    .in_glyph_y(in_glyph_y), .in_glyph_width(in_glyph_width),
    .in_glyph_height(in_glyph_height), .in_offset_x(in_offset_x),
    .in_offset_y(in_offset_y), .in_advance_width(in_advance_width),
    .in_avail_width(in_avail_width), .in_row_number(in_row_number),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel_color(out_pixel_color), .out_last_pixel(out_last_pixel),
    .out_run_width(out_run_width)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("[glyph_row_rasterizer_top] ERROR");
    $finish;
  end

  function automatic int imin(int a, int b);
    return (a < b) ? a : b;
  endfunction

  function automatic void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic int atlas_index(longint pix);
    return int'((pix >> 1) % grr_pkg::DEF_ATLAS_BYTES);
  endfunction

  function automatic logic [15:0] palette_color(logic [3:0] idx);
    return palette_q[idx[3:2]][idx[1:0]*16 +: 16];
  endfunction

  function automatic row_plan_t layout_row(glyph_req_t r);
    row_plan_t p;
    int lower, sx, sy, gw, gh, adv, avail, row, data_end, run;
    p = '{run: 0, first: 0, stop: 0, glyph: 1'b0, base: 64'sd0};
    sx = int'(r.sx);
    sy = int'(r.sy);
    gw = int'(r.gw);
    gh = int'(r.gh);
    adv = int'(r.adv);
    avail = int'(r.avail);
    row = int'(r.row);
    lower = imin(imin(int'(clip_h), int'(font_h)), grr_pkg::DEF_MAX_GLYPH_HEIGHT);
    if (row >= lower || sx >= avail) return p;
    data_end = sx + gw;
    run = (data_end > adv) ? data_end : adv;
    if (data_end > avail) begin
      data_end = avail;
      run = avail;
    end else if (run > avail) begin
      run = avail;
    end
    run = imin(run, grr_pkg::DEF_MAX_GLYPH_WIDTH);
    data_end = imin(data_end, run);
    p.run = run;
    p.first = sx;
    p.stop = data_end;
    p.glyph = (row >= sy) && (row < sy + gh);
    p.base = longint'(int'(r.gy) + (p.glyph ? row - sy : 0)) * longint'(stride_q)
             + longint'(r.gx);
    return p;
  endfunction

  // updates the atlas copy or queues the pixels of one accepted row
  function automatic void model_accept(glyph_req_t r);
    row_plan_t p;
    pixel_t px;
    longint pix;
    logic [7:0] b;
    logic [3:0] nib;
    items_sent++;
    if (r.action == ACT_WRITE) begin
      atlas_copy[r.addr] = r.data;
      written_map[r.addr] = 1'b1;
      writes_sent++;
      return;
    end
    rows_sent++;
    p = layout_row(r);
    for (int pos = 0; pos < p.run; pos++) begin
      px.color = palette_color(4'd0);
      if (p.glyph && pos >= p.first && pos < p.stop) begin
        pix = p.base + pos - p.first;
        b = atlas_copy[atlas_index(pix)];
        nib = pix[0] ? b[3:0] : b[7:4];
        px.color = palette_color(nib);
      end
      px.last = (pos + 1 == p.run);
      px.width = p.run[5:0];
      pending_pixels.push_back(px);
    end
  endfunction

  function automatic glyph_req_t rand_fields();
    glyph_req_t r;
    r.action = ACT_RENDER;
    r.addr = 14'($urandom_range(0, 16383));
    r.data = 8'($urandom_range(0, 255));
    r.gx = 12'($urandom_range(0, 4095));
    r.gy = 10'($urandom_range(0, 1023));
    r.gw = 6'($urandom_range(0, 48));
    r.gh = 6'($urandom_range(0, 62));
    r.sx = 6'($urandom_range(0, 48));
    r.sy = 6'($urandom_range(0, 62));
    r.adv = 6'($urandom_range(0, 48));
    r.avail = 9'($urandom_range(0, 320));
    r.row = 6'($urandom_range(0, 61));
    return r;
  endfunction

  function automatic glyph_req_t mk_write(int addr, int data);
    glyph_req_t r;
    r = rand_fields();
    r.action = ACT_WRITE;
    r.addr = addr[13:0];
    r.data = data[7:0];
    return r;
  endfunction

  function automatic glyph_req_t mk_row(int gx, int gy, int gw, int gh, int sx, int sy,
                                        int adv, int avail, int row);
    glyph_req_t r;
    r = rand_fields();
    r.gx = gx[11:0];
    r.gy = gy[9:0];
    r.gw = gw[5:0];
    r.gh = gh[5:0];
    r.sx = sx[5:0];
    r.sy = sy[5:0];
    r.adv = adv[5:0];
    r.avail = avail[8:0];
    r.row = row[5:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // valid is left high after a transfer; the next call or settle() updates it
  task automatic send_item(glyph_req_t r);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action = r.action;
    in_atlas_addr = r.addr;
    in_atlas_byte = r.data;
    in_glyph_x = r.gx;
    in_glyph_y = r.gy;
    in_glyph_width = r.gw;
    in_glyph_height = r.gh;
    in_offset_x = r.sx;
    in_offset_y = r.sy;
    in_advance_width = r.adv;
    in_avail_width = r.avail;
    in_row_number = r.row;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_accept(r);
  endtask

  // stores any not yet written atlas byte the row would read, then sends the row
  task automatic send_row(glyph_req_t r);
    row_plan_t p;
    int b;
    int pos;
    p = layout_row(r);
    if (p.glyph) begin
      for (pos = p.first; pos < p.stop; pos++) begin
        b = atlas_index(p.base + pos - p.first);
        if (!written_map[b]) send_item(mk_write(b, $urandom_range(0, 255)));
      end
    end
    send_item(r);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_pixels.size() != 0) begin
      flag($sformatf("%0d expected pixels never arrived", pending_pixels.size()));
      pending_pixels.delete();
    end
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [grr_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      grr_pkg::CFG_ATLAS_WIDTH:    stride_q = val[12:0];
      grr_pkg::CFG_FONT_HEIGHT:    font_h = val[5:0];
      grr_pkg::CFG_CLIP_HEIGHT:    clip_h = val[8:0];
      grr_pkg::CFG_PALETTE_LO:     palette_q[0] = val;
      grr_pkg::CFG_PALETTE_MID_LO: palette_q[1] = val;
      grr_pkg::CFG_PALETTE_MID_HI: palette_q[2] = val;
      grr_pkg::CFG_PALETTE_HI:     palette_q[3] = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_config(int aw, int fh, int ch);
    settle();
    write_reg(grr_pkg::CFG_ATLAS_WIDTH, 64'(aw));
    write_reg(grr_pkg::CFG_FONT_HEIGHT, 64'(fh));
    write_reg(grr_pkg::CFG_CLIP_HEIGHT, 64'(ch));
  endtask

  task automatic load_palette();
    write_reg(grr_pkg::CFG_PALETTE_LO, {$urandom, $urandom});
    write_reg(grr_pkg::CFG_PALETTE_MID_LO, {$urandom, $urandom});
    write_reg(grr_pkg::CFG_PALETTE_MID_HI, {$urandom, $urandom});
    write_reg(grr_pkg::CFG_PALETTE_HI, {$urandom, $urandom});
  endtask

  function automatic glyph_req_t rand_row();
    int gx, gy, gw, gh, sx, sy, adv, avail, row, lower, k, r;
    if ($urandom_range(0, 3) != 0) begin
      k = $urandom_range(0, 3);
      gx = pool_x[k];
      gy = pool_y[k];
    end else begin
      gx = $urandom_range(0, 4095);
      gy = $urandom_range(0, 1023);
    end
    gw = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(0, 48);
    gh = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 16) : $urandom_range(0, 62);
    sx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(0, 48);
    sy = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(0, 62);
    adv = ($urandom_range(0, 9) < 6) ? imin(sx + gw + $urandom_range(0, 3), 48)
                                      : $urandom_range(0, 48);
    r = $urandom_range(0, 9);
    avail = (r < 6) ? $urandom_range(sx + 1, 320) :
            (r < 8) ? $urandom_range(0, 48) : $urandom_range(0, 320);
    lower = imin(imin(int'(clip_h), int'(font_h)), grr_pkg::DEF_MAX_GLYPH_HEIGHT);
    if (lower > 0 && $urandom_range(0, 9) < 8)
      row = $urandom_range(0, imin(lower - 1, sy + gh + 1));
    else
      row = $urandom_range(0, 61);
    return mk_row(gx, gy, gw, gh, sx, sy, adv, avail, row);
  endfunction

  task automatic test_reset_values();
    gaps_on = 1'b0;
    send_row(mk_row(0, 0, 8, 4, 1, 1, 10, 320, 2));
    send_row(mk_row(100, 200, 16, 8, 0, 0, 16, 320, 7));
    send_row(mk_row(3, 4, 5, 62, 0, 0, 5, 320, 61));
    gaps_on = 1'b1;
  endtask

  task automatic test_directed_cases();
    load_config(24, 62, 320);
    load_palette();
    send_item(mk_write(0, 8'hFF));
    send_item(mk_write(14'h3FFF, 8'h00));
    send_item(mk_write(14'h2AAA, 8'h5A));
    send_row(mk_row(0, 0, 8, 8, 2, 1, 12, 320, 3));
    send_row(mk_row(0, 0, 8, 8, 2, 1, 12, 320, 0));   // above bitmap
    send_row(mk_row(0, 0, 8, 8, 2, 1, 12, 320, 9));   // below bitmap
    send_row(mk_row(0, 0, 8, 8, 10, 0, 12, 10, 0));   // shift past available width
    send_row(mk_row(0, 0, 8, 8, 0, 0, 12, 0, 0));
    send_row(mk_row(0, 0, 0, 8, 0, 0, 0, 5, 0));      // empty run
    send_row(mk_row(0, 0, 48, 4, 0, 0, 0, 320, 2));
    send_row(mk_row(0, 0, 40, 4, 20, 0, 0, 320, 1));  // saturates, bitmap cut at 48
    send_row(mk_row(0, 0, 48, 4, 48, 0, 48, 320, 0));
    send_row(mk_row(0, 0, 10, 4, 2, 0, 4, 7, 1));     // bitmap clipped
    send_row(mk_row(0, 0, 4, 4, 0, 0, 30, 10, 1));    // advance clipped
    send_row(mk_row(0, 0, 3, 2, 5, 0, 48, 320, 0));
    send_row(mk_row(0, 0, 1, 1, 0, 0, 0, 1, 0));
    send_row(mk_row(4095, 1023, 48, 62, 0, 0, 48, 320, 61));
    send_row(mk_row(7, 3, 5, 0, 1, 0, 8, 320, 0));
    send_row(mk_row(7, 3, 5, 1, 1, 62, 8, 320, 61));
    send_row(mk_row(1, 2, 47, 61, 1, 1, 47, 319, 61));
  endtask

  task automatic test_register_extremes();
    load_config(1, 1, 320);
    send_row(mk_row(5, 9, 6, 3, 1, 0, 8, 320, 0));
    send_row(mk_row(5, 9, 6, 3, 1, 0, 8, 320, 1));    // row past font height
    send_row(mk_row(4095, 1023, 48, 62, 0, 0, 48, 320, 0));
    load_config(4096, 62, 0);
    send_row(mk_row(0, 0, 8, 8, 0, 0, 8, 320, 0));    // nothing visible
    load_config(4096, 62, 61);
    send_row(mk_row(4095, 1023, 48, 62, 0, 0, 48, 320, 60));  // wraps the atlas
    send_row(mk_row(4095, 1023, 48, 62, 0, 0, 48, 320, 61));
    load_config(4096, 40, 320);
    send_row(mk_row(4001, 517, 33, 62, 3, 2, 40, 300, 39));
    send_row(mk_row(4001, 517, 33, 62, 3, 2, 40, 300, 40));
    load_config(9, 62, 320);
    write_reg(grr_pkg::CFG_PALETTE_LO, '1);
    write_reg(grr_pkg::CFG_PALETTE_MID_LO, '0);
    write_reg(grr_pkg::CFG_PALETTE_MID_HI, '1);
    write_reg(grr_pkg::CFG_PALETTE_HI, '0);
    send_row(mk_row(2, 2, 12, 6, 2, 1, 16, 320, 3));
    settle();
    write_reg(grr_pkg::CFG_PALETTE_LO, '0);
    write_reg(grr_pkg::CFG_PALETTE_MID_LO, '1);
    write_reg(grr_pkg::CFG_PALETTE_MID_HI, '0);
    write_reg(grr_pkg::CFG_PALETTE_HI, '1);
    send_row(mk_row(2, 2, 12, 6, 2, 1, 16, 320, 3));
  endtask

  task automatic test_random_traffic();
    int start, phase, steps, r, aw, fh, ch;
    start = items_sent;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      r = $urandom_range(0, 99);
      aw = (r < 15) ? 1 : (r < 30) ? 4096 :
           (r < 70) ? $urandom_range(8, 64) : $urandom_range(1, 4096);
      r = $urandom_range(0, 99);
      fh = (r < 20) ? 62 : (r < 30) ? 1 : $urandom_range(1, 62);
      r = $urandom_range(0, 99);
      ch = (r < 5) ? 0 : (r < 15) ? 320 :
           (r < 75) ? $urandom_range(100, 320) : $urandom_range(0, 320);
      load_config(aw, fh, ch);
      load_palette();
      for (int k = 0; k < 4; k++) begin
        pool_x[k] = $urandom_range(0, 4095);
        pool_y[k] = $urandom_range(0, 1023);
      end
      steps = 0;
      while (items_sent - start < (phase + 1) * RANDOM_ITEMS / RANDOM_PHASES) begin
        if (steps % 16 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 99) < 15)
          send_item(mk_write($urandom_range(0, 16383), $urandom_range(0, 255)));
        else
          send_row(rand_row());
        steps++;
      end
    end
  endtask

  initial begin : sink_pacing
    int hold, calm, r;
    hold = 0;
    calm = 0;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (calm > 0) begin
        calm--;
        out_ready = 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_ready = 1'b0;
      end else begin
        r = $urandom_range(0, 999);
        if (r < 5) begin
          calm = $urandom_range(50, 300);
          out_ready = 1'b1;
        end else if (r < 650) begin
          out_ready = 1'b1;
        end else begin
          out_ready = 1'b0;
          hold = (r < 900) ? $urandom_range(0, 2) :
                 (r < 985) ? $urandom_range(3, 9) : $urandom_range(15, 40);
        end
      end
    end
  end

  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        flag($sformatf("unexpected pixel: color %h last %b width %0d",
                       out_pixel_color, out_last_pixel, out_run_width));
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel_color !== want.color || out_last_pixel !== want.last ||
            out_run_width !== want.width)
          flag($sformatf("pixel %0d: expected color %h last %b width %0d, got %h %b %0d",
                         pixels_checked, want.color, want.last, want.width,
                         out_pixel_color, out_last_pixel, out_run_width));
      end
      pixels_checked++;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_action = ACT_WRITE;
    in_atlas_addr = '0;
    in_atlas_byte = '0;
    in_glyph_x = '0;
    in_glyph_y = '0;
    in_glyph_width = '0;
    in_glyph_height = '0;
    in_offset_x = '0;
    in_offset_y = '0;
    in_advance_width = '0;
    in_avail_width = '0;
    in_row_number = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_values();
    test_directed_cases();
    test_register_extremes();
    test_random_traffic();
    settle();
    $display("covered %0d row requests and %0d atlas writes over %0d register writes",
             rows_sent, writes_sent, cfg_writes);
    $display("%0d pixel transfers compared, %0d mismatches", pixels_checked, mismatches);
    if (mismatches == 0)
      $display("[glyph_row_rasterizer_top] OK");
    else
      $display("[glyph_row_rasterizer_top] ERROR");
    $finish;
  end

endmodule
